// File: hw/rtl/dmtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmtf_pkg
// shared constants, pattern table and control types of the markup tag filter
// ----------------------------------------------------------------------------
package dmtf_pkg;

  localparam int MAX_TAG_LEN = 64;
  localparam int LEN_W       = $clog2(MAX_TAG_LEN + 1);
  localparam int ADDR_W      = $clog2(MAX_TAG_LEN);
  localparam int PAT_COUNT   = 49;
  localparam int PAT_MAX     = 11;
  localparam int PAT_LW      = 4;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;

  // pattern text right-aligned: last char in the low byte
  localparam logic [8*PAT_MAX-1:0] PAT_TEXT [PAT_COUNT] = '{
    88'("<script"), 88'("</script"), 88'("<iframe"), 88'("</iframe"),
    88'("<object"), 88'("</object"), 88'("<embed"), 88'("</embed"),
    88'("<applet"), 88'("</applet"), 88'("<meta"), 88'("</meta"),
    88'("<link"), 88'("</link"), 88'("<style"), 88'("</style"),
    88'("<base"), 88'("</base"), 88'("<form"), 88'("</form"),
    88'("<input"), 88'("</input"), 88'("<button"), 88'("</button"),
    88'("<textarea"), 88'("</textarea"), 88'("<select"), 88'("</select"),
    88'("<option"), 88'("</option"),
    88'("onload"), 88'("onerror"), 88'("onclick"), 88'("onmouseover"),
    88'("onmouseout"), 88'("onkeydown"), 88'("onkeyup"), 88'("onkeypress"),
    88'("onfocus"), 88'("onblur"), 88'("onchange"), 88'("onsubmit"),
    88'("onreset"), 88'("onselect"), 88'("onunload"),
    88'("javascript:"), 88'("vbscript:"), 88'("data:"), 88'("livescript:")
  };

  localparam logic [PAT_LW-1:0] PAT_LEN [PAT_COUNT] = '{
    4'd7, 4'd8, 4'd7, 4'd8, 4'd7, 4'd8, 4'd6, 4'd7, 4'd7, 4'd8,
    4'd5, 4'd6, 4'd5, 4'd6, 4'd6, 4'd7, 4'd5, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd10, 4'd7, 4'd8, 4'd7, 4'd8,
    4'd6, 4'd7, 4'd7, 4'd11, 4'd10, 4'd9, 4'd7, 4'd10, 4'd7, 4'd6,
    4'd8, 4'd8, 4'd7, 4'd8, 4'd8,
    4'd11, 4'd9, 4'd5, 4'd11
  };

  // what an accepted item causes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_PASS  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;
  localparam logic [1:0] ACT_END   = 2'd3;

  typedef struct packed {
    logic accept;
    logic load_pass;
    logic start_read;
    logic emit_mem;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic [1:0] act;
    logic       rd_final;
  } status_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dmtf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmtf_ctrl
// sequencer: takes items, then walks the tag buffer or sends the end marker
// ----------------------------------------------------------------------------
module dmtf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  dmtf_pkg::status_t     status,
  output dmtf_pkg::cmd_t        cmd
);
  import dmtf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = status.slot_free;
        if (in_valid && status.slot_free) begin
          cmd.accept    = 1'b1;
          cmd.load_pass = (status.act == ACT_PASS);
          if (status.act == ACT_FLUSH) state_next = S_RD;
          if (status.act == ACT_END)   state_next = S_END;
        end
      end
      S_RD: begin
        cmd.start_read = 1'b1;
        state_next     = S_WR;
      end
      S_WR: begin
        if (status.slot_free) begin
          cmd.emit_mem = 1'b1;
          state_next   = status.rd_final ? S_IDLE : S_RD;
        end
      end
      S_END: begin
        if (status.slot_free) begin
          cmd.emit_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// File: hw/rtl/dmtf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmtf_datapath
// tag buffer, pattern window and matcher, output register
// ----------------------------------------------------------------------------
module dmtf_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  input  dmtf_pkg::cmd_t    cmd,
  output dmtf_pkg::status_t status,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              has_byte,
  output logic              out_last
);
  import dmtf_pkg::*;

  logic [7:0]              mem [MAX_TAG_LEN];
  logic [7:0]              mem_q;
  logic [LEN_W-1:0]        tag_length;
  logic                    inside_tag;
  logic                    danger;
  logic                    flush_last;
  logic [ADDR_W-1:0]       rd_idx;
  logic [PAT_MAX-1:0][7:0] win;

  logic                    is_open;
  logic                    full;
  logic [LEN_W-1:0]        base_len;
  logic [LEN_W-1:0]        len_next;
  logic [PAT_MAX-1:0][7:0] win_next;
  logic                    hit;
  logic                    m;
  logic                    danger_next;
  logic                    slot_free;

  assign slot_free = !out_valid || out_ready;
  assign is_open   = !inside_tag && in_byte == CH_LT;
  assign base_len  = is_open ? '0 : tag_length;
  assign full      = base_len == LEN_W'(MAX_TAG_LEN);
  assign len_next  = full ? base_len : base_len + 1'b1;
  assign win_next  = {win[PAT_MAX-2:0], fold(in_byte)};

  // substring check on the newest bytes of the tag
  always_comb begin
    hit = 1'b0;
    for (int p = 0; p < PAT_COUNT; p++) begin
      m = !full && (len_next >= LEN_W'(PAT_LEN[p]));
      for (int i = 0; i < PAT_MAX; i++) begin
        if (i < int'(PAT_LEN[p]) && win_next[i] != PAT_TEXT[p][8*i +: 8]) m = 1'b0;
      end
      hit = hit | m;
    end
  end

  assign danger_next = (!is_open && danger) || full || hit;

  always_comb begin
    status.slot_free = slot_free;
    status.rd_final  = ({1'b0, rd_idx} + 1'b1) == tag_length;
    if (!inside_tag && in_byte != CH_LT)  status.act = ACT_PASS;
    else if (is_open)                     status.act = in_last ? ACT_FLUSH : ACT_NONE;
    else if (in_byte == CH_GT)
      status.act = !danger_next ? ACT_FLUSH : (in_last ? ACT_END : ACT_NONE);
    else                                  status.act = in_last ? ACT_FLUSH : ACT_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag <= 1'b0;
      tag_length <= '0;
      danger     <= 1'b0;
    end else if (cmd.accept && status.act != ACT_PASS) begin
      tag_length <= len_next;
      danger     <= danger_next;
      inside_tag <= !(in_last || (inside_tag && in_byte == CH_GT));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.act != ACT_PASS && !full) begin
      mem[base_len[ADDR_W-1:0]] <= in_byte;
      win                       <= win_next;
    end
    if (cmd.accept) begin
      flush_last <= in_last;
      rd_idx     <= '0;
    end
    if (cmd.start_read) mem_q <= mem[rd_idx];
    if (cmd.emit_mem)   rd_idx <= rd_idx + 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pass || cmd.emit_mem || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pass) begin
      out_byte <= in_byte;
      has_byte <= 1'b1;
      out_last <= in_last;
    end else if (cmd.emit_mem) begin
      out_byte <= mem_q;
      has_byte <= 1'b1;
      out_last <= flush_last && status.rd_final;
    end else if (cmd.emit_end) begin
      out_byte <= '0;
      has_byte <= 1'b0;
      out_last <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dangerous_markup_tag_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dangerous_markup_tag_filter_top
// drops markup tags that name unsafe elements, event handlers or url schemes
// ----------------------------------------------------------------------------
// Bytes outside a tag pass straight to the output register, which can hold
// a finished byte while the next item is taken. A '<' opens a tag; its bytes
// (up to 64) are stored in a buffer memory and checked as they arrive
// against 49 lowercased patterns in a sliding window, so no extra time is
// spent at the closing '>'. A safe tag is then read back from the buffer one
// byte at a time, each by a memory read and then an output load, and the
// input stalls for that whole replay. A dropped tag is never read back; if
// it closes the text, one empty end marker (has_byte low) is sent. A text
// that ends inside a tag replays the buffer as it stands.
module dangerous_markup_tag_filter_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            out_last
);
  import dmtf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing of accept / replay / end marker
  dmtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // buffer, matcher and output register
  dmtf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire
